[src/tpg_pkg.sv]
package tpg_pkg;

   // Register indexes on the configuration port
   localparam logic [3:0] CSR_PILOT_HALF_LEN     = 4'd0;
   localparam logic [3:0] CSR_SYNC_FIRST_LEN     = 4'd1;
   localparam logic [3:0] CSR_SYNC_SECOND_LEN    = 4'd2;
   localparam logic [3:0] CSR_ZERO_HALF_LEN      = 4'd3;
   localparam logic [3:0] CSR_ONE_HALF_LEN       = 4'd4;
   localparam logic [3:0] CSR_HEADER_PILOT_COUNT = 4'd5;
   localparam logic [3:0] CSR_DATA_PILOT_COUNT   = 4'd6;
   localparam logic [3:0] CSR_PAUSE_LEN          = 4'd7;

   // Register reset values
   localparam logic [15:0] RST_PILOT_HALF_LEN     = 16'd2168;
   localparam logic [15:0] RST_SYNC_FIRST_LEN     = 16'd667;
   localparam logic [15:0] RST_SYNC_SECOND_LEN    = 16'd735;
   localparam logic [15:0] RST_ZERO_HALF_LEN      = 16'd855;
   localparam logic [15:0] RST_ONE_HALF_LEN       = 16'd1710;
   localparam logic [13:0] RST_HEADER_PILOT_COUNT = 14'd8063;
   localparam logic [13:0] RST_DATA_PILOT_COUNT   = 14'd3223;
   localparam logic [23:0] RST_PAUSE_LEN          = 24'd10500000;

   localparam logic [23:0] ACC_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [7:0]  elapsed_tstates;
      logic [7:0]  tape_byte;
      logic [15:0] block_length;
      logic        block_is_header;
      logic        no_more_blocks;
   } tpg_req_type;

   typedef struct packed {
      logic        ear_level;
      logic [15:0] block_number;
      logic [15:0] byte_offset;
      logic        block_started;
      logic        tape_stopped;
   } tpg_rsp_type;

   typedef struct packed {
      logic [15:0] pilot_half_len;
      logic [15:0] sync_first_len;
      logic [15:0] sync_second_len;
      logic [15:0] zero_half_len;
      logic [15:0] one_half_len;
      logic [13:0] header_pilot_count;
      logic [13:0] data_pilot_count;
      logic [23:0] pause_len;
   } tpg_cfg_type;

   typedef enum logic [5:0] {
      PH_PILOT  = 6'b000001,
      PH_SYNC1  = 6'b000010,
      PH_SYNC2  = 6'b000100,
      PH_STREAM = 6'b001000,
      PH_BIT    = 6'b010000,
      PH_PAUSE  = 6'b100000
   } tpg_phase_type;

   // Add elapsed T-states, saturating at the accumulator width
   function automatic logic [23:0] tpg_acc_add(input logic [23:0] acc, input logic [7:0] t);
      logic [24:0] sum;
      sum = {1'b0, acc} + {17'd0, t};
      return sum[24] ? ACC_MAX : sum[23:0];
   endfunction

endpackage

[src/tpg_csr.sv]
module tpg_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [23:0]         csr_data,
   output tpg_pkg::tpg_cfg_type cfg
);
   import tpg_pkg::*;

   tpg_cfg_type cfg_ff;
   tpg_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PILOT_HALF_LEN:     cfg_in.pilot_half_len     = csr_data[15:0];
            CSR_SYNC_FIRST_LEN:     cfg_in.sync_first_len     = csr_data[15:0];
            CSR_SYNC_SECOND_LEN:    cfg_in.sync_second_len    = csr_data[15:0];
            CSR_ZERO_HALF_LEN:      cfg_in.zero_half_len      = csr_data[15:0];
            CSR_ONE_HALF_LEN:       cfg_in.one_half_len       = csr_data[15:0];
            CSR_HEADER_PILOT_COUNT: cfg_in.header_pilot_count = csr_data[13:0];
            CSR_DATA_PILOT_COUNT:   cfg_in.data_pilot_count   = csr_data[13:0];
            CSR_PAUSE_LEN:          cfg_in.pause_len          = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pilot_half_len     <= RST_PILOT_HALF_LEN;
         cfg_ff.sync_first_len     <= RST_SYNC_FIRST_LEN;
         cfg_ff.sync_second_len    <= RST_SYNC_SECOND_LEN;
         cfg_ff.zero_half_len      <= RST_ZERO_HALF_LEN;
         cfg_ff.one_half_len       <= RST_ONE_HALF_LEN;
         cfg_ff.header_pilot_count <= RST_HEADER_PILOT_COUNT;
         cfg_ff.data_pilot_count   <= RST_DATA_PILOT_COUNT;
         cfg_ff.pause_len          <= RST_PAUSE_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/tpg_core.sv]
module tpg_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tpg_pkg::tpg_req_type req,
   input  tpg_pkg::tpg_cfg_type cfg,
   output tpg_pkg::tpg_rsp_type rsp
);
   import tpg_pkg::*;

   logic          level_ff, level_in;
   logic          toggle_ff, toggle_in;
   tpg_phase_type phase_ff, phase_in;
   logic          header_mode_ff, header_mode_in;
   logic          starting_ff, starting_in;
   logic [13:0]   pilot_done_ff, pilot_done_in;
   logic [23:0]   acc_ff, acc_in;
   logic [15:0]   bit_half_len_ff, bit_half_len_in;
   logic          half_done_ff, half_done_in;
   logic [15:0]   byte_pointer_ff, byte_pointer_in;
   logic [2:0]    bit_index_ff, bit_index_in;
   logic [15:0]   block_index_ff, block_index_in;
   logic [13:0]   pilot_count;
   logic [24:0]   pause_sum;
   logic          data_bit;
   logic          started;
   logic          stopped;

   always_comb begin
      level_in        = level_ff;
      toggle_in       = toggle_ff;
      phase_in        = phase_ff;
      header_mode_in  = header_mode_ff;
      starting_in     = starting_ff;
      pilot_done_in   = pilot_done_ff;
      acc_in          = acc_ff;
      bit_half_len_in = bit_half_len_ff;
      half_done_in    = half_done_ff;
      byte_pointer_in = byte_pointer_ff;
      bit_index_in    = bit_index_ff;
      block_index_in  = block_index_ff;
      started         = 1'b0;
      stopped         = 1'b0;
      pilot_count     = '0;
      pause_sum       = '0;
      data_bit        = 1'b0;

      if (req.no_more_blocks) begin
         // End of tape: force low and step back to the last block
         level_in = 1'b0;
         if (block_index_ff != 16'd0) begin
            block_index_in = block_index_ff - 16'd1;
         end
         stopped = 1'b1;
      end else begin
         if (starting_ff) begin
            started         = 1'b1;
            starting_in     = 1'b0;
            header_mode_in  = req.block_is_header;
            phase_in        = PH_PILOT;
            byte_pointer_in = '0;
            bit_index_in    = '0;
            acc_in          = '0;
            pilot_done_in   = '0;
            toggle_in       = 1'b1;
         end
         pilot_count = header_mode_in ? cfg.header_pilot_count : cfg.data_pilot_count;

         case (phase_in)
            PH_PILOT: begin
               if (pilot_done_in < pilot_count) begin
                  if (toggle_in) begin
                     level_in  = ~level_in;
                     toggle_in = 1'b0;
                  end
                  if (acc_in >= {8'd0, cfg.pilot_half_len}) begin
                     pilot_done_in = pilot_done_in + 14'd1;
                     acc_in        = '0;
                     toggle_in     = 1'b1;
                  end
                  acc_in = tpg_acc_add(acc_in, req.elapsed_tstates);
               end else begin
                  acc_in   = '0;
                  phase_in = PH_SYNC1;
               end
            end
            PH_SYNC1: begin
               if (toggle_in) begin
                  level_in  = ~level_in;
                  toggle_in = 1'b0;
               end
               if (acc_in >= {8'd0, cfg.sync_first_len}) begin
                  acc_in    = '0;
                  toggle_in = 1'b1;
                  phase_in  = PH_SYNC2;
               end else begin
                  acc_in = tpg_acc_add(acc_in, req.elapsed_tstates);
               end
            end
            PH_SYNC2: begin
               if (toggle_in) begin
                  level_in  = ~level_in;
                  toggle_in = 1'b0;
               end
               if (acc_in >= {8'd0, cfg.sync_second_len}) begin
                  acc_in          = '0;
                  byte_pointer_in = '0;
                  toggle_in       = 1'b1;
                  phase_in        = PH_STREAM;
               end else begin
                  acc_in = tpg_acc_add(acc_in, req.elapsed_tstates);
               end
            end
            PH_STREAM: begin
               if (byte_pointer_in >= req.block_length) begin
                  phase_in = PH_PAUSE;
                  acc_in   = '0;
               end else begin
                  // Take bits MSB first
                  data_bit     = req.tape_byte[3'd7 - bit_index_in];
                  bit_index_in = bit_index_in + 3'd1;
                  if (bit_index_in == 3'd0) begin
                     byte_pointer_in = byte_pointer_in + 16'd1;
                  end
                  bit_half_len_in = data_bit ? cfg.one_half_len : cfg.zero_half_len;
                  toggle_in       = 1'b1;
                  acc_in          = '0;
                  half_done_in    = 1'b0;
                  phase_in        = PH_BIT;
               end
            end
            PH_BIT: begin
               if (toggle_in) begin
                  level_in  = ~level_in;
                  toggle_in = 1'b0;
               end
               if (acc_in >= {8'd0, bit_half_len_in}) begin
                  if (!half_done_in) begin
                     half_done_in = 1'b1;
                     toggle_in    = 1'b1;
                     acc_in       = '0;
                  end else begin
                     phase_in = PH_STREAM;
                  end
               end else begin
                  acc_in = tpg_acc_add(acc_in, req.elapsed_tstates);
               end
            end
            PH_PAUSE: begin
               pause_sum = {1'b0, acc_in} + {17'd0, req.elapsed_tstates};
               acc_in    = pause_sum[24] ? ACC_MAX : pause_sum[23:0];
               if (pause_sum > {1'b0, cfg.pause_len}) begin
                  block_index_in = block_index_ff + 16'd1;
                  starting_in    = 1'b1;
               end
            end
            default: begin
               phase_in = PH_PILOT;
            end
         endcase
      end
   end

   assign rsp.ear_level     = level_in;
   assign rsp.block_number  = block_index_in;
   assign rsp.byte_offset   = byte_pointer_in;
   assign rsp.block_started = started;
   assign rsp.tape_stopped  = stopped;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= 1'b0;
         toggle_ff       <= 1'b1;
         phase_ff        <= PH_PILOT;
         header_mode_ff  <= 1'b0;
         starting_ff     <= 1'b1;
         pilot_done_ff   <= '0;
         acc_ff          <= '0;
         bit_half_len_ff <= '0;
         half_done_ff    <= 1'b0;
         byte_pointer_ff <= '0;
         bit_index_ff    <= '0;
         block_index_ff  <= '0;
      end else if (advance) begin
         level_ff        <= level_in;
         toggle_ff       <= toggle_in;
         phase_ff        <= phase_in;
         header_mode_ff  <= header_mode_in;
         starting_ff     <= starting_in;
         pilot_done_ff   <= pilot_done_in;
         acc_ff          <= acc_in;
         bit_half_len_ff <= bit_half_len_in;
         half_done_ff    <= half_done_in;
         byte_pointer_ff <= byte_pointer_in;
         bit_index_ff    <= bit_index_in;
         block_index_ff  <= block_index_in;
      end
   end

endmodule

[src/tape_pulse_generator_top.sv]
// Cassette ear-signal generator. Feed one tick item per emulated instruction
// and take back exactly one result item per tick: the ear level, the block
// being played and the offset of the byte that the next tick must carry in
// tape_byte. Each block plays as a pilot tone, two sync half-pulses, every bit
// of the block MSB first as two equal half-pulses, then a pause before the
// block index advances; at end of tape the level drops low and the index
// steps back. The block sustains one item per clock cycle while results are
// not stalled. An accepted item sits in the input register, the whole state
// update runs in one pass of logic in the core, and the result lands in the
// output register once that register is free or is being emptied. A stalled
// result holds the input back only while both registers are full.
// Configuration writes are always ready and take effect on the next item;
// write them only while no item is in flight.
module tape_pulse_generator_top (
   input  logic                 clock,
   input  logic                 reset,
   // tick items in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tpg_pkg::tpg_req_type req_data,
   // result items out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tpg_pkg::tpg_rsp_type rsp_data,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [3:0]           csr_index,
   input  logic [23:0]          csr_data
);
   import tpg_pkg::*;

   tpg_req_type req_ff;
   logic        req_valid_ff, req_valid_in;
   tpg_rsp_type rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   tpg_rsp_type core_rsp;
   tpg_cfg_type cfg;
   logic        advance;
   logic        req_take;

   // Move the held item into the result register when that slot is free
   // or is being emptied this cycle.
   assign advance   = req_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   // Hold off new items only when the input register cannot drain.
   assign req_stall = req_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign req_valid_in = req_stall ? req_valid_ff : req_valid;
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tpg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   // Control: valid flags of the two registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

endmodule

[src/tpg_checker.sv]
module tpg_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tpg_pkg::tpg_rsp_type rsp_data
);
   import tpg_pkg::*;

   // A stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled result item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // End of tape forces the ear level low
   a_stop_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tape_stopped |-> !rsp_data.ear_level)
      else $error("ear level high at end of tape");

   // A block cannot start on a tick that stops the tape
   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.block_started && rsp_data.tape_stopped))
      else $error("block start and tape stop on one item");

   // Input stalls only when the result side is full and held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with result side free");

endmodule

bind tape_pulse_generator_top tpg_checker u_tpg_checker (.*);
